// ----- sv/kcgf_pkg.sv -----
// Shared constants, types and state codes for the keypoint gradient fill block.
package kcgf_pkg;

  localparam int unsigned POS_W        = 6;
  localparam int unsigned CHAN_W       = 8;
  localparam int unsigned WEIGHT_W     = 10;  // weight of one is 1 << WEIGHT_W
  localparam int unsigned M_W          = WEIGHT_W + 1;
  localparam int unsigned DVD_W        = POS_W + WEIGHT_W;
  localparam int unsigned DIV_CNT_W    = $clog2(DVD_W);
  localparam int unsigned STRIP_LENGTH = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DSTART,
    ST_DWAIT,
    ST_MUL,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    CH_R,
    CH_G,
    CH_B
  } chan_e;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [POS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [M_W-1:0]  quot;
  } div_rsp_t;

endpackage

// ----- sv/kcgf_if.sv -----
// Valid/ready channel interfaces for keypoint words and pixel words.
interface kcgf_key_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [kcgf_pkg::POS_W-1:0]    key_pos;
  logic [kcgf_pkg::CHAN_W-1:0]   key_r;
  logic [kcgf_pkg::CHAN_W-1:0]   key_g;
  logic [kcgf_pkg::CHAN_W-1:0]   key_b;

  modport source (output valid, req_type, key_pos, key_r, key_g, key_b, input ready);
  modport sink   (input valid, req_type, key_pos, key_r, key_g, key_b, output ready);
endinterface

interface kcgf_pix_if;
  logic                          valid;
  logic                          ready;
  logic [kcgf_pkg::POS_W-1:0]    pixel_index;
  logic [kcgf_pkg::CHAN_W-1:0]   pixel_r;
  logic [kcgf_pkg::CHAN_W-1:0]   pixel_g;
  logic [kcgf_pkg::CHAN_W-1:0]   pixel_b;
  logic                          last_of_run;

  modport source (output valid, pixel_index, pixel_r, pixel_g, pixel_b, last_of_run,
                  input ready);
  modport sink   (input valid, pixel_index, pixel_r, pixel_g, pixel_b, last_of_run,
                  output ready);
endinterface

// ----- sv/kcgf_div.sv -----
// Iterative restoring divider: one quotient bit per cycle for the blend weight.
module kcgf_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kcgf_pkg::div_req_t  req_i,
  output kcgf_pkg::div_rsp_t  rsp_o
);

  logic [kcgf_pkg::DVD_W-1:0]     dvd_q, dvd_d;
  logic [kcgf_pkg::POS_W-1:0]     dsr_q, dsr_d;
  logic [kcgf_pkg::POS_W-1:0]     rem_q, rem_d;
  logic [kcgf_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [kcgf_pkg::POS_W:0]       trial;
  logic                           qbit;

  assign trial = {rem_q, dvd_q[kcgf_pkg::DVD_W-1]};
  assign qbit  = (trial >= {1'b0, dsr_q});

  always_comb begin
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dvd_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when it fits
      rem_d = qbit ? kcgf_pkg::POS_W'(trial - {1'b0, dsr_q})
                   : trial[kcgf_pkg::POS_W-1:0];
      dvd_d = {dvd_q[kcgf_pkg::DVD_W-2:0], qbit};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == kcgf_pkg::DIV_CNT_W'(kcgf_pkg::DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  // weight never exceeds one, so the upper quotient bits are zero
  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q[kcgf_pkg::M_W-1:0];

endmodule

// ----- sv/keypoint_color_gradient_fill.sv -----
// Keypoint gradient fill: turns color keypoints into interpolated strip pixels.
// Start keypoint: its pixel is offered in the cycle after the keypoint is taken.
// Continuing keypoint: each pixel takes a divider launch, the divider steps (one per
// dividend bit), the divider's done strobe, a shared multiply per channel (R, G, B) and
// an output state that holds while stalled. Up to 63 pixels per keypoint.
// Reset (async, active low) clears the previous keypoint to position 0, black.
module keypoint_color_gradient_fill (
  input  logic          clk_i,
  input  logic          rst_ni,
  kcgf_key_if.sink      key_i,
  kcgf_pix_if.source    pix_o
);

  localparam logic [kcgf_pkg::POS_W-1:0] StripLast =
    kcgf_pkg::POS_W'(kcgf_pkg::STRIP_LENGTH - 1);
  localparam int unsigned PROD_W = kcgf_pkg::M_W + kcgf_pkg::CHAN_W + 2;

  kcgf_pkg::state_e state_q, state_d;

  logic [kcgf_pkg::POS_W-1:0]  prev_pos_q;
  logic [kcgf_pkg::CHAN_W-1:0] prev_r_q, prev_g_q, prev_b_q;
  logic [kcgf_pkg::CHAN_W-1:0] key_r_q, key_g_q, key_b_q;
  logic [kcgf_pkg::POS_W-1:0]  key_pos_q;
  logic [kcgf_pkg::POS_W-1:0]  k_q, end_q, span_q;
  logic [kcgf_pkg::M_W-1:0]    m_q;
  kcgf_pkg::chan_e             ch_q;
  logic [kcgf_pkg::POS_W-1:0]  pix_idx_q;
  logic [kcgf_pkg::CHAN_W-1:0] pix_r_q, pix_g_q, pix_b_q;
  logic                        last_q;

  logic                        in_acc, out_acc;
  logic [kcgf_pkg::POS_W-1:0]  end_c;
  logic [kcgf_pkg::POS_W:0]    first_k;
  logic                        start_emit, run_emit;

  kcgf_pkg::div_req_t          div_req;
  kcgf_pkg::div_rsp_t          div_rsp;

  logic [kcgf_pkg::CHAN_W-1:0] op_a, op_b;
  logic signed [kcgf_pkg::CHAN_W:0] diff;
  logic signed [PROD_W-1:0]    prod, blend_sum;
  logic [kcgf_pkg::CHAN_W-1:0] blend;

  assign in_acc  = key_i.valid && key_i.ready;
  assign out_acc = pix_o.valid && pix_o.ready;

  // clip the run at the strip end; the weights still use the full span
  assign end_c      = (key_i.key_pos > StripLast) ? StripLast : key_i.key_pos;
  assign first_k    = {1'b0, prev_pos_q} + 1'b1;
  assign start_emit = !key_i.req_type && (key_i.key_pos <= StripLast);
  assign run_emit   = key_i.req_type && (key_i.key_pos > prev_pos_q) &&
                      (first_k <= {1'b0, end_c});

  assign div_req.start    = (state_q == kcgf_pkg::ST_DSTART);
  assign div_req.dividend = {kcgf_pkg::POS_W'(k_q - prev_pos_q),
                             kcgf_pkg::WEIGHT_W'(0)};
  assign div_req.divisor  = span_q;

  kcgf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // shared blend unit: prev + floor(m * (new - prev) / 1024)
  always_comb begin
    case (ch_q)
      kcgf_pkg::CH_R: begin
        op_a = prev_r_q;
        op_b = key_r_q;
      end
      kcgf_pkg::CH_G: begin
        op_a = prev_g_q;
        op_b = key_g_q;
      end
      default: begin
        op_a = prev_b_q;
        op_b = key_b_q;
      end
    endcase
  end

  assign diff      = $signed({1'b0, op_b}) - $signed({1'b0, op_a});
  assign prod      = $signed({{(PROD_W - kcgf_pkg::M_W){1'b0}}, m_q}) *
                     $signed({{(PROD_W - kcgf_pkg::CHAN_W - 1){diff[kcgf_pkg::CHAN_W]}}, diff});
  assign blend_sum = (prod >>> kcgf_pkg::WEIGHT_W) +
                     $signed({{(PROD_W - kcgf_pkg::CHAN_W){1'b0}}, op_a});
  assign blend     = blend_sum[kcgf_pkg::CHAN_W-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kcgf_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (start_emit) begin
            state_d = kcgf_pkg::ST_OUT;
          end else if (run_emit) begin
            state_d = kcgf_pkg::ST_DSTART;
          end
        end
      end
      kcgf_pkg::ST_DSTART: state_d = kcgf_pkg::ST_DWAIT;
      kcgf_pkg::ST_DWAIT: begin
        if (div_rsp.done) begin
          state_d = kcgf_pkg::ST_MUL;
        end
      end
      kcgf_pkg::ST_MUL: begin
        if (ch_q == kcgf_pkg::CH_B) begin
          state_d = kcgf_pkg::ST_OUT;
        end
      end
      kcgf_pkg::ST_OUT: begin
        if (out_acc) begin
          state_d = last_q ? kcgf_pkg::ST_IDLE : kcgf_pkg::ST_DSTART;
        end
      end
      default: state_d = kcgf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kcgf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // previous keypoint: advance at once unless a run still needs it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pos_q <= '0;
      prev_r_q   <= '0;
      prev_g_q   <= '0;
      prev_b_q   <= '0;
    end else if (in_acc && !run_emit) begin
      prev_pos_q <= key_i.key_pos;
      prev_r_q   <= key_i.key_r;
      prev_g_q   <= key_i.key_g;
      prev_b_q   <= key_i.key_b;
    end else if (out_acc && last_q) begin
      prev_pos_q <= key_pos_q;
      prev_r_q   <= key_r_q;
      prev_g_q   <= key_g_q;
      prev_b_q   <= key_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_pos_q <= key_i.key_pos;
      key_r_q   <= key_i.key_r;
      key_g_q   <= key_i.key_g;
      key_b_q   <= key_i.key_b;
      span_q    <= key_i.key_pos - prev_pos_q;
      k_q       <= first_k[kcgf_pkg::POS_W-1:0];
      end_q     <= end_c;
      if (start_emit) begin
        pix_idx_q <= key_i.key_pos;
        pix_r_q   <= key_i.key_r;
        pix_g_q   <= key_i.key_g;
        pix_b_q   <= key_i.key_b;
        last_q    <= 1'b1;
      end
    end
    if (state_q == kcgf_pkg::ST_DWAIT && div_rsp.done) begin
      m_q  <= div_rsp.quot;
      ch_q <= kcgf_pkg::CH_R;
    end
    if (state_q == kcgf_pkg::ST_MUL) begin
      case (ch_q)
        kcgf_pkg::CH_R: begin
          pix_r_q <= blend;
          ch_q    <= kcgf_pkg::CH_G;
        end
        kcgf_pkg::CH_G: begin
          pix_g_q <= blend;
          ch_q    <= kcgf_pkg::CH_B;
        end
        default: begin
          pix_b_q   <= blend;
          pix_idx_q <= k_q;
          last_q    <= (k_q == end_q);
        end
      endcase
    end
    if (state_q == kcgf_pkg::ST_OUT && out_acc && !last_q) begin
      k_q <= k_q + 1'b1;
    end
  end

  assign key_i.ready       = (state_q == kcgf_pkg::ST_IDLE);
  assign pix_o.valid       = (state_q == kcgf_pkg::ST_OUT);
  assign pix_o.pixel_index = pix_idx_q;
  assign pix_o.pixel_r     = pix_r_q;
  assign pix_o.pixel_g     = pix_g_q;
  assign pix_o.pixel_b     = pix_b_q;
  assign pix_o.last_of_run = last_q;

endmodule

// ----- sv/kcgf_checker.sv -----
// Port-level assertions for the keypoint gradient fill, bound to the top level.
module kcgf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_last_i
);

  logic out_acc;

  assign out_acc = out_valid_i && out_ready_i;

  // a stalled pixel word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("pixel word dropped while stalled");

  a_no_ready_with_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("ready for a keypoint while a pixel word waits");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !out_last_i |=> !in_ready_i)
    else $error("run ended before its last pixel");

  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_last_i |=> in_ready_i)
    else $error("block not ready after last pixel of a run");

endmodule

bind keypoint_color_gradient_fill kcgf_checker u_kcgf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (key_i.valid),
  .in_ready_i  (key_i.ready),
  .out_valid_i (pix_o.valid),
  .out_ready_i (pix_o.ready),
  .out_last_i  (pix_o.last_of_run)
);

// ----- tb/tb_keypoint_color_gradient_fill.sv -----
// Self-checking testbench for keypoint_color_gradient_fill: keypoint words in, pixel words out.
`timescale 1ns / 1ps

module tb_keypoint_color_gradient_fill;
  import kcgf_pkg::*;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_CONT  = 1'b1;

  localparam int RAND_ITEMS  = 400;
  localparam int DIR_ROWS    = 22;
  localparam int HOLD_CYCLES = 400;
  // a whole pixel's work plus the long hold and random stalls, taken several times over
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_SHOWN   = 10;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_ONE,
    CHK_NONE
  } chk_e;

  typedef struct packed {
    logic              req_type;
    logic [POS_W-1:0]  pos;
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } key_t;

  typedef struct packed {
    logic [POS_W-1:0]  idx;
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
    logic              last;
  } pixel_t;

  typedef struct packed {
    chk_e   chk;
    key_t   key;
    pixel_t px;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  kcgf_key_if key_bus ();
  kcgf_pix_if pix_bus ();

  keypoint_color_gradient_fill u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  (key_bus),
    .pix_o  (pix_bus)
  );

  // previous keypoint as the predictor sees it
  logic [POS_W-1:0]  grad_pos;
  logic [CHAN_W-1:0] grad_r;
  logic [CHAN_W-1:0] grad_g;
  logic [CHAN_W-1:0] grad_b;

  pixel_t run_px[$];
  pixel_t pixels_due_q[$];
  dir_row_t dir_tab [DIR_ROWS];

  int fails;
  int idle_cyc;
  int src_idle_pct;
  int snk_idle_pct;
  bit hold_req;
  bit hold_done;
  int hold_cnt;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic logic [CHAN_W-1:0] mix_chan(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b,
                                                 input int unsigned m);
    int unsigned acc;
    acc = ((1024 - m) * a + m * b) / 1024;
    return acc[CHAN_W-1:0];
  endfunction

  // Work out the pixels of one keypoint into run_px and advance the previous keypoint.
  function automatic void grad_fill_predict(input key_t k);
    int unsigned span;
    int unsigned m;
    int unsigned kk;
    pixel_t px;
    run_px.delete();
    if (k.req_type == REQ_START) begin
      if (k.pos < STRIP_LENGTH) begin
        px = '{k.pos, k.r, k.g, k.b, 1'b0};
        run_px.push_back(px);
      end
    end else if (k.pos > grad_pos) begin
      span = k.pos - grad_pos;
      for (kk = grad_pos + 1; kk <= k.pos && kk < STRIP_LENGTH; kk++) begin
        m = ((kk - grad_pos) * 1024) / span;
        px.idx  = kk[POS_W-1:0];
        px.r    = mix_chan(grad_r, k.r, m);
        px.g    = mix_chan(grad_g, k.g, m);
        px.b    = mix_chan(grad_b, k.b, m);
        px.last = 1'b0;
        run_px.push_back(px);
      end
    end
    if (run_px.size() > 0) run_px[run_px.size()-1].last = 1'b1;
    grad_pos = k.pos;
    grad_r   = k.r;
    grad_g   = k.g;
    grad_b   = k.b;
  endfunction

  function automatic logic [CHAN_W-1:0] rand_chan();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return CHAN_W'($urandom_range(255));
    endcase
  endfunction

  // Offer one keypoint word from a falling edge, hold until taken, queue its pixels.
  task automatic send_key(input key_t k, input chk_e chk, input pixel_t typed,
                          output int n_px);
    while ($urandom_range(99) < src_idle_pct) begin
      key_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    key_bus.valid    <= 1'b1;
    key_bus.req_type <= k.req_type;
    key_bus.key_pos  <= k.pos;
    key_bus.key_r    <= k.r;
    key_bus.key_g    <= k.g;
    key_bus.key_b    <= k.b;
    @(posedge clk_i);
    while (!key_bus.ready) @(posedge clk_i);
    grad_fill_predict(k);
    case (chk)
      CHK_MODEL: begin
        foreach (run_px[i]) pixels_due_q.push_back(run_px[i]);
        n_px = run_px.size();
      end
      CHK_ONE: begin
        pixels_due_q.push_back(typed);
        n_px = 1;
      end
      default: n_px = 0;
    endcase
    @(negedge clk_i);
  endtask

  // receiver: random stalls, plus one long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      pix_bus.ready <= 1'b0;
      hold_cnt++;
      if (hold_cnt >= HOLD_CYCLES) hold_done = 1'b1;
    end else begin
      pix_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    pixel_t got;
    pixel_t want;
    if (rst_ni && pix_bus.valid && pix_bus.ready) begin
      got = '{pix_bus.pixel_index, pix_bus.pixel_r, pix_bus.pixel_g, pix_bus.pixel_b,
              pix_bus.last_of_run};
      if (pixels_due_q.size() == 0) begin
        fails++;
        if (fails <= MAX_SHOWN)
          $display("unexpected pixel word: idx %0d rgb %02h %02h %02h last %0b",
                   got.idx, got.r, got.g, got.b, got.last);
      end else begin
        want = pixels_due_q.pop_front();
        if (got.idx !== want.idx || got.r !== want.r || got.g !== want.g ||
            got.b !== want.b || got.last !== want.last) begin
          fails++;
          if (fails <= MAX_SHOWN)
            $display("pixel mismatch: exp idx %0d rgb %02h %02h %02h last %0b, got idx %0d rgb %02h %02h %02h last %0b",
                     want.idx, want.r, want.g, want.b, want.last,
                     got.idx, got.r, got.g, got.b, got.last);
        end
      end
    end
  end

  // watchdog: too long without any word moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (key_bus.valid && key_bus.ready) || (pix_bus.valid && pix_bus.ready)) begin
      idle_cyc = 0;
    end else begin
      idle_cyc++;
      if (idle_cyc >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("** keypoint_color_gradient_fill: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    key_t k;
    int n_px;
    int lit_items;
    int line_pos;
    int step;
    int runs;

    rst_ni           = 1'b0;
    key_bus.valid    = 1'b0;
    key_bus.req_type = REQ_START;
    key_bus.key_pos  = '0;
    key_bus.key_r    = '0;
    key_bus.key_g    = '0;
    key_bus.key_b    = '0;
    pix_bus.ready    = 1'b0;
    fails            = 0;
    idle_cyc         = 0;
    hold_req         = 1'b0;
    hold_done        = 1'b0;
    hold_cnt         = 0;
    src_idle_pct     = 23;
    snk_idle_pct     = 58;
    grad_pos         = '0;
    grad_r           = '0;
    grad_g           = '0;
    grad_b           = '0;
    lit_items        = 0;

    dir_tab = '{
      // continuing keypoints straight after reset: black at position 0 is the previous one
      '{CHK_NONE,  '{REQ_CONT,  6'd0,  8'h00, 8'h00, 8'h00}, '0},
      '{CHK_MODEL, '{REQ_CONT,  6'd3,  8'hFF, 8'h80, 8'h01}, '0},
      '{CHK_ONE,   '{REQ_START, 6'd63, 8'hFF, 8'hFF, 8'hFF}, '{6'd63, 8'hFF, 8'hFF, 8'hFF, 1'b1}},
      // at and before the previous keypoint: nothing out, state still moves
      '{CHK_NONE,  '{REQ_CONT,  6'd63, 8'h00, 8'h00, 8'h00}, '0},
      '{CHK_NONE,  '{REQ_CONT,  6'd10, 8'h12, 8'h34, 8'h56}, '0},
      '{CHK_ONE,   '{REQ_START, 6'd0,  8'h00, 8'h00, 8'h00}, '{6'd0,  8'h00, 8'h00, 8'h00, 1'b1}},
      // full strip in one run
      '{CHK_MODEL, '{REQ_CONT,  6'd63, 8'hFF, 8'hFF, 8'hFF}, '0},
      '{CHK_ONE,   '{REQ_START, 6'd20, 8'hAA, 8'h55, 8'h0F}, '{6'd20, 8'hAA, 8'h55, 8'h0F, 1'b1}},
      '{CHK_ONE,   '{REQ_CONT,  6'd21, 8'h55, 8'hAA, 8'hF0}, '{6'd21, 8'h55, 8'hAA, 8'hF0, 1'b1}},
      '{CHK_MODEL, '{REQ_CONT,  6'd40, 8'h00, 8'hFF, 8'h00}, '0},
      '{CHK_ONE,   '{REQ_CONT,  6'd41, 8'hFF, 8'h00, 8'hFF}, '{6'd41, 8'hFF, 8'h00, 8'hFF, 1'b1}},
      '{CHK_ONE,   '{REQ_START, 6'd0,  8'hFF, 8'hFF, 8'hFF}, '{6'd0,  8'hFF, 8'hFF, 8'hFF, 1'b1}},
      '{CHK_ONE,   '{REQ_CONT,  6'd1,  8'h00, 8'h00, 8'h00}, '{6'd1,  8'h00, 8'h00, 8'h00, 1'b1}},
      '{CHK_ONE,   '{REQ_START, 6'd62, 8'h01, 8'h02, 8'h03}, '{6'd62, 8'h01, 8'h02, 8'h03, 1'b1}},
      '{CHK_ONE,   '{REQ_CONT,  6'd63, 8'h80, 8'h40, 8'h20}, '{6'd63, 8'h80, 8'h40, 8'h20, 1'b1}},
      '{CHK_NONE,  '{REQ_CONT,  6'd63, 8'h11, 8'h22, 8'h33}, '0},
      '{CHK_NONE,  '{REQ_CONT,  6'd0,  8'hFF, 8'hFF, 8'hFF}, '0},
      '{CHK_MODEL, '{REQ_CONT,  6'd2,  8'h00, 8'h00, 8'h00}, '0},
      '{CHK_ONE,   '{REQ_START, 6'd5,  8'h0F, 8'hF0, 8'h3C}, '{6'd5,  8'h0F, 8'hF0, 8'h3C, 1'b1}},
      // start after start: no blend between them
      '{CHK_ONE,   '{REQ_START, 6'd9,  8'hC3, 8'h3C, 8'h99}, '{6'd9,  8'hC3, 8'h3C, 8'h99, 1'b1}},
      '{CHK_MODEL, '{REQ_CONT,  6'd32, 8'hFF, 8'h00, 8'h7F}, '0},
      '{CHK_MODEL, '{REQ_CONT,  6'd47, 8'h01, 8'hFE, 8'h80}, '0}
    };

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++)
      send_key(dir_tab[i].key, dir_tab[i].chk, dir_tab[i].px, n_px);

    // random part: mostly well-formed lines, some loose keypoints in between
    while (lit_items < RAND_ITEMS) begin
      if (lit_items >= 2 * RAND_ITEMS / 3) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_req     = 1'b1;
      end else if (lit_items >= RAND_ITEMS / 3) begin
        src_idle_pct = 58;
        snk_idle_pct = 23;
      end
      if ($urandom_range(99) < 85) begin
        line_pos = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(15);
        k = '{REQ_START, POS_W'(line_pos), rand_chan(), rand_chan(), rand_chan()};
        send_key(k, CHK_MODEL, '0, n_px);
        if (n_px > 0) lit_items++;
        runs = $urandom_range(1, 5);
        for (int j = 0; j < runs; j++) begin
          step = ($urandom_range(9) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 6);
          line_pos = (line_pos + step > 63) ? 63 : line_pos + step;
          k = '{REQ_CONT, POS_W'(line_pos), rand_chan(), rand_chan(), rand_chan()};
          send_key(k, CHK_MODEL, '0, n_px);
          if (n_px > 0) lit_items++;
        end
      end else begin
        k = '{1'($urandom_range(1)), POS_W'($urandom_range(63)),
              rand_chan(), rand_chan(), rand_chan()};
        send_key(k, CHK_MODEL, '0, n_px);
        if (n_px > 0) lit_items++;
      end
    end
    key_bus.valid <= 1'b0;

    while (pixels_due_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fails == 0) begin
      $display("** keypoint_color_gradient_fill: PASSED **");
    end else begin
      $display("** keypoint_color_gradient_fill: FAILED **");
    end
    $finish;
  end

endmodule
